/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |-> cons) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/lspf_pkg.sv */
// Shared types, constants and helper functions of the scan point filter.
package lspf_pkg;

  localparam int PI_Q13        = 25736;
  localparam int HALF_PI_Q13   = 12868;
  localparam int TWO_PI_Q13    = 51472;
  // multiple of two pi that lifts any raw angle sum above zero
  localparam int ANGLE_OFFSET  = 843317248;
  localparam int DIV_SHIFT     = 47;
  localparam logic [31:0] RECIP_TWO_PI = 32'((64'd1 << DIV_SHIFT) / 64'(TWO_PI_Q13));
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam int MAX_BOUNDS = 4;
  localparam int XY_W       = 34;
  localparam int Z_W        = 33;
  localparam int SIDX_W     = 11;
  localparam int ATAN_LEN   = 24;

  localparam logic signed [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  localparam logic [2:0] REG_ANGLE_START   = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
  localparam logic [2:0] REG_MIN_RANGE     = 3'd2;
  localparam logic [2:0] REG_SAMPLE_STRIDE = 3'd3;
  localparam logic [2:0] REG_BOUND_COUNT   = 3'd4;
  localparam logic [2:0] REG_IGNORE_BOUNDS = 3'd5;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [13:0] angle_step;
    logic [15:0] min_range;
    logic [7:0]  sample_stride;
    logic [2:0]  bound_count;
    logic [63:0] ignore_bounds;
  } cfg_t;

  // true when |angle| falls strictly inside a bound pair or past a trailing odd bound
  function automatic logic angle_ignored(logic [15:0] mag, logic [2:0] count,
                                         logic [63:0] bounds);
    logic [2:0] n;
    logic hit;
    n = (count > 3'(MAX_BOUNDS)) ? 3'(MAX_BOUNDS) : count;
    hit = 1'b0;
    for (int i = 0; i + 1 < MAX_BOUNDS; i += 2) begin
      if ((3'(i + 1) < n) && (bounds[16*i +: 16] < mag) && (mag < bounds[16*(i+1) +: 16]))
        hit = 1'b1;
    end
    for (int i = 0; i < MAX_BOUNDS; i++) begin
      if (n[0] && (3'(i + 1) == n) && (bounds[16*i +: 16] < mag))
        hit = 1'b1;
    end
    return hit;
  endfunction

  // round Q14 to integer, undo the half-turn rotation, clamp
  function automatic logic [16:0] finish(logic signed [XY_W-1:0] v, logic flip);
    logic signed [XY_W-1:0] r;
    logic signed [XY_W-1:0] sat_max;
    logic signed [XY_W-1:0] sat_min;
    sat_max = XY_W'(65535);
    sat_min = XY_W'(-65535);
    r = (v + XY_W'(8192)) >>> 14;
    if (flip)
      r = -r;
    if (r > sat_max)
      r = sat_max;
    else if (r < sat_min)
      r = sat_min;
    return r[16:0];
  endfunction

endpackage

/* src/lspf_mod_cell.sv */
// One restoring step of the index-modulo-stride chain.
module lspf_mod_cell #(
  parameter int IDX_W = 11,
  parameter int BIT   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [7:0]       stride,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] in_idx,
  input  logic [15:0]      in_range,
  input  logic [7:0]       in_rem,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_idx,
  output logic [15:0]      out_range,
  output logic [7:0]       out_rem
);

  logic [8:0] shifted;
  logic [8:0] rem_next;

  always_comb begin
    shifted  = {in_rem, in_idx[BIT]};
    rem_next = (shifted >= {1'b0, stride}) ? shifted - {1'b0, stride} : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_idx   <= in_idx;
      out_range <= in_range;
      out_rem   <= rem_next[7:0];
    end
  end

endmodule

/* src/lspf_angle_pipe.sv */
// Angle generation, wrap into one turn, masking and CORDIC seed.
module lspf_angle_pipe #(
  parameter int IDX_W = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  lspf_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  input  logic [IDX_W-1:0]               in_idx,
  input  logic [15:0]                    in_range,
  input  logic [7:0]                     in_rem,
  output logic                           out_valid,
  output logic [IDX_W-1:0]               out_idx,
  output logic                           out_flip,
  output logic signed [lspf_pkg::XY_W-1:0] out_x,
  output logic signed [lspf_pkg::Z_W-1:0]  out_z
);

  localparam int PROD_W = IDX_W + 15;
  localparam int SUM_W  = 34;

  logic                     v1, v2, v3, v4, v5;
  logic [IDX_W-1:0]         i1, i2, i3, i4, i5;
  logic [15:0]              r1, r2, r3, r4, r5;
  logic [29:0]              x2, x3, x4, x5;
  logic signed [PROD_W-1:0] p1;
  logic [45:0]              g1;
  logic [31:0]              u2, u3;
  logic [15:0]              q3;
  logic [16:0]              m4;
  logic signed [15:0]       a5;

  logic signed [SUM_W-1:0]  sum2;
  logic [63:0]              mq;
  logic [16:0]              wr;
  logic [15:0]              mag;
  logic                     drop;
  logic signed [15:0]       a6;
  logic                     flip6;

  always_comb begin
    sum2 = SUM_W'($signed(cfg.angle_start)) + SUM_W'(p1) + SUM_W'(lspf_pkg::PI_Q13)
         + SUM_W'(lspf_pkg::ANGLE_OFFSET);
    mq   = 64'(u2) * 64'(lspf_pkg::RECIP_TWO_PI);
    wr   = (m4 >= 17'(lspf_pkg::TWO_PI_Q13)) ? m4 - 17'(lspf_pkg::TWO_PI_Q13) : m4;
    mag  = a5[15] ? 16'(-a5) : 16'(a5);
    drop = lspf_pkg::angle_ignored(mag, cfg.bound_count, cfg.ignore_bounds)
         || (r5 < cfg.min_range);
    if (a5 > 16'sd12868) begin
      a6    = a5 - 16'(lspf_pkg::PI_Q13);
      flip6 = 1'b1;
    end else if (a5 < -16'sd12868) begin
      a6    = a5 + 16'(lspf_pkg::PI_Q13);
      flip6 = 1'b1;
    end else begin
      a6    = a5;
      flip6 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && (in_rem == 8'd0);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5 && !drop;
    end
    if (en) begin
      // raw angle and gain-scaled range
      p1 <= PROD_W'($signed(cfg.angle_step)) * PROD_W'($signed({1'b0, in_idx}));
      g1 <= 46'(in_range) * 46'(lspf_pkg::GAIN_Q30);
      i1 <= in_idx;
      r1 <= in_range;
      // biased to nonnegative, then floor divide by two pi via reciprocal
      u2 <= sum2[31:0];
      x2 <= 30'((g1 + 46'd32768) >> 16);
      i2 <= i1;
      r2 <= r1;
      q3 <= mq[62:47];
      u3 <= u2;
      x3 <= x2;
      i3 <= i2;
      r3 <= r2;
      m4 <= 17'(u3 - 32'(q3) * 32'(lspf_pkg::TWO_PI_Q13));
      x4 <= x3;
      i4 <= i3;
      r4 <= r3;
      // quotient can be one short: final correction here
      a5 <= 16'(wr - 17'(lspf_pkg::PI_Q13));
      x5 <= x4;
      i5 <= i4;
      r5 <= r4;
      out_idx  <= i5;
      out_flip <= flip6;
      out_x    <= lspf_pkg::XY_W'(x5);
      out_z    <= {a6, 17'b0};
    end
  end

endmodule

/* src/lspf_cordic_cell.sv */
// One rotation step of the CORDIC chain.
module lspf_cordic_cell #(
  parameter int IDX_W = 11,
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [IDX_W-1:0]                  in_idx,
  input  logic                              in_flip,
  input  logic signed [lspf_pkg::XY_W-1:0]  in_x,
  input  logic signed [lspf_pkg::XY_W-1:0]  in_y,
  input  logic signed [lspf_pkg::Z_W-1:0]   in_z,
  output logic                              out_valid,
  output logic [IDX_W-1:0]                  out_idx,
  output logic                              out_flip,
  output logic signed [lspf_pkg::XY_W-1:0]  out_x,
  output logic signed [lspf_pkg::XY_W-1:0]  out_y,
  output logic signed [lspf_pkg::Z_W-1:0]   out_z
);

  localparam logic signed [lspf_pkg::Z_W-1:0] ATAN =
    lspf_pkg::Z_W'(lspf_pkg::ATAN_Q30[STAGE]);

  logic signed [lspf_pkg::XY_W-1:0] dx;
  logic signed [lspf_pkg::XY_W-1:0] dy;

  always_comb begin
    dx = in_y >>> STAGE;
    dy = in_x >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_idx  <= in_idx;
      out_flip <= in_flip;
      if (!in_z[lspf_pkg::Z_W-1]) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end
    end
  end

endmodule

/* src/lidar_scan_point_filter.sv */
// Top level of the lidar scan point filter.
// Input stream: one beat per range sample, s_tdata = range, s_tuser = first sample
// of a scan (resets the sample index to zero). Every sample advances the index,
// which wraps after MAX_SAMPLES - 1.
// Output stream: one beat per kept sample carrying x, y and its index. Samples off
// the stride, inside a masked angle band or below min_range give no beat.
// Throughput: one beat per cycle while the output is not stalled. The pipeline
// holds a front register, one modulo cell per index bit, six angle/mask stages,
// one CORDIC cell per iteration and the output register.
// A stalled output freezes the whole chain, and s_tready drops with it; no beat is
// lost. Reset clears the valid bits, the index counter and the registers to their
// defaults (stride one, everything else zero). Configuration is written through
// cfg_wr_en / cfg_index / cfg_data and takes effect at once; write only while idle.
module lidar_scan_point_filter #(
  parameter int MAX_SAMPLES   = 2048,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] range_value
  input  logic        s_tuser,   // [0] scan_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [16:0] point_x, [33:17] point_y, [44:34] sample_index
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int XY_W  = lspf_pkg::XY_W;
  localparam int Z_W   = lspf_pkg::Z_W;
  localparam int IW    = (IDX_W > lspf_pkg::SIDX_W) ? IDX_W : lspf_pkg::SIDX_W;

  lspf_pkg::cfg_t cfg;
  logic           en;
  logic [7:0]     stride_eff;

  logic [IDX_W-1:0] idx_cnt;
  logic [IDX_W:0]   idx_cnt_ext;
  logic [IDX_W:0]   idx_plus;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] idx_cur;

  logic             mc_valid [IDX_W+1];
  logic [IDX_W-1:0] mc_idx   [IDX_W+1];
  logic [15:0]      mc_range [IDX_W+1];
  logic [7:0]       mc_rem   [IDX_W+1];

  logic                   cd_valid [CORDIC_STAGES+1];
  logic [IDX_W-1:0]       cd_idx   [CORDIC_STAGES+1];
  logic                   cd_flip  [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] cd_x     [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] cd_y     [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  cd_z     [CORDIC_STAGES+1];

  logic [IW-1:0] idx_wide;

  assign en         = !m_tvalid || m_tready;
  assign s_tready   = en;
  assign stride_eff = (cfg.sample_stride == 8'd0) ? 8'd1 : cfg.sample_stride;

  always_comb begin
    idx_cnt_ext = {1'b0, idx_cnt};
    idx_cur     = s_tuser ? '0 : idx_cnt;
    idx_plus    = s_tuser ? (IDX_W+1)'(1) : idx_cnt_ext + (IDX_W+1)'(1);
    idx_next    = (idx_plus >= (IDX_W+1)'(MAX_SAMPLES)) ? '0 : idx_plus[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start   <= '0;
      cfg.angle_step    <= '0;
      cfg.min_range     <= '0;
      cfg.sample_stride <= 8'd1;
      cfg.bound_count   <= '0;
      cfg.ignore_bounds <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lspf_pkg::REG_ANGLE_START:   cfg.angle_start   <= cfg_data[15:0];
        lspf_pkg::REG_ANGLE_STEP:    cfg.angle_step    <= cfg_data[13:0];
        lspf_pkg::REG_MIN_RANGE:     cfg.min_range     <= cfg_data[15:0];
        lspf_pkg::REG_SAMPLE_STRIDE: cfg.sample_stride <= cfg_data[7:0];
        lspf_pkg::REG_BOUND_COUNT:   cfg.bound_count   <= cfg_data[2:0];
        lspf_pkg::REG_IGNORE_BOUNDS: cfg.ignore_bounds <= cfg_data;
        default: ;
      endcase
    end
  end

  // index counter and front register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_cnt     <= '0;
      mc_valid[0] <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        idx_cnt <= idx_next;
      if (en)
        mc_valid[0] <= s_tvalid;
    end
    if (en) begin
      mc_idx[0]   <= idx_cur;
      mc_range[0] <= s_tdata;
    end
  end

  assign mc_rem[0] = 8'd0;

  // remainder of index by stride, one index bit per cell, MSB first
  for (genvar k = 0; k < IDX_W; k++) begin : g_mod
    lspf_mod_cell #(
      .IDX_W (IDX_W),
      .BIT   (IDX_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stride    (stride_eff),
      .in_valid  (mc_valid[k]),
      .in_idx    (mc_idx[k]),
      .in_range  (mc_range[k]),
      .in_rem    (mc_rem[k]),
      .out_valid (mc_valid[k+1]),
      .out_idx   (mc_idx[k+1]),
      .out_range (mc_range[k+1]),
      .out_rem   (mc_rem[k+1])
    );
  end

  lspf_angle_pipe #(
    .IDX_W (IDX_W)
  ) u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (mc_valid[IDX_W]),
    .in_idx    (mc_idx[IDX_W]),
    .in_range  (mc_range[IDX_W]),
    .in_rem    (mc_rem[IDX_W]),
    .out_valid (cd_valid[0]),
    .out_idx   (cd_idx[0]),
    .out_flip  (cd_flip[0]),
    .out_x     (cd_x[0]),
    .out_z     (cd_z[0])
  );

  assign cd_y[0] = '0;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    lspf_cordic_cell #(
      .IDX_W (IDX_W),
      .STAGE (s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cd_valid[s]),
      .in_idx    (cd_idx[s]),
      .in_flip   (cd_flip[s]),
      .in_x      (cd_x[s]),
      .in_y      (cd_y[s]),
      .in_z      (cd_z[s]),
      .out_valid (cd_valid[s+1]),
      .out_idx   (cd_idx[s+1]),
      .out_flip  (cd_flip[s+1]),
      .out_x     (cd_x[s+1]),
      .out_y     (cd_y[s+1]),
      .out_z     (cd_z[s+1])
    );
  end

  assign idx_wide = IW'(cd_idx[CORDIC_STAGES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cd_valid[CORDIC_STAGES];
    end
    if (en) begin
      m_tdata <= {3'b000,
                  idx_wide[lspf_pkg::SIDX_W-1:0],
                  lspf_pkg::finish(cd_y[CORDIC_STAGES], cd_flip[CORDIC_STAGES]),
                  lspf_pkg::finish(cd_x[CORDIC_STAGES], cd_flip[CORDIC_STAGES])};
    end
  end

  `ASSERT_NEXT(a_scan_restart, clk, rst, s_tvalid && s_tready && s_tuser, idx_cnt == IDX_W'(1), "index did not restart at scan start")
  `ASSERT_RST(a_idx_bound, clk, rst, idx_cnt_ext < (IDX_W+1)'(MAX_SAMPLES), "index counter past scan length")
  `ASSERT_IMPLY(a_point_sat, clk, rst, m_tvalid, (m_tdata[16:0] != 17'h10000) && (m_tdata[33:17] != 17'h10000), "point outside saturation range")

endmodule

/* test/tb_lidar_scan_point_filter.sv */
// Self-checking testbench for the lidar scan point filter: directed and random scans.
module tb_lidar_scan_point_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCAN_LEN   = 2048;
  localparam int NUM_STAGES = 16;
  localparam int QUIET_CYC  = 50;   // comfortably above the pipeline depth

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    logic [10:0] sidx;
  } point_t;

  typedef struct {
    logic [15:0] rng;
    logic        first;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] range_value
  logic        s_tuser = 1'b0; // [0] scan_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [16:0] point_x, [33:17] point_y, [44:34] sample_index
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  lidar_scan_point_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the register file and the sample counter
  logic signed [15:0] cfg_start  = '0;
  logic signed [13:0] cfg_step   = '0;
  logic [15:0]        cfg_minr   = '0;
  logic [7:0]         cfg_stride = 8'd1;
  logic [2:0]         cfg_bcount = '0;
  logic [63:0]        cfg_bounds = '0;
  int                 scan_pos   = 0;

  sample_t pending_samples[$];
  point_t  expected_points[$];
  int      err_count = 0;

  function automatic logic [16:0] q14_round(input longint v, input bit neg);
    longint r;
    r = (v + 8192) >>> 14;
    if (neg)
      r = -r;
    if (r > 65535)
      r = 65535;
    if (r < -65535)
      r = -65535;
    return r[16:0];
  endfunction

  // advances the sample counter; returns 1 when the sample yields a point
  function automatic bit predict_point(input logic [15:0] rng, input logic first,
                                       output point_t p);
    longint idx, a, mag, x, y, z, dx, dy;
    int     stride, n;
    bit     flip;
    p = '0;
    idx = first ? 0 : scan_pos;
    scan_pos = (idx + 1 >= SCAN_LEN) ? 0 : int'(idx + 1);
    stride = (cfg_stride == 0) ? 1 : int'(cfg_stride);
    if (idx % stride != 0)
      return 1'b0;

    a = longint'(cfg_start) + longint'(cfg_step) * idx;
    a = ((a + lspf_pkg::PI_Q13) % lspf_pkg::TWO_PI_Q13 + lspf_pkg::TWO_PI_Q13)
        % lspf_pkg::TWO_PI_Q13 - lspf_pkg::PI_Q13;

    mag = (a < 0) ? -a : a;
    n = (cfg_bcount > lspf_pkg::MAX_BOUNDS) ? lspf_pkg::MAX_BOUNDS : int'(cfg_bcount);
    for (int i = 0; i + 1 < n; i += 2) begin
      if (longint'(cfg_bounds[16*i +: 16]) < mag && mag < longint'(cfg_bounds[16*(i+1) +: 16]))
        return 1'b0;
    end
    if (n % 2 == 1 && longint'(cfg_bounds[16*(n-1) +: 16]) < mag)
      return 1'b0;
    if (rng < cfg_minr)
      return 1'b0;

    // fold obtuse angles into the right half-plane, negate the result later
    flip = 1'b0;
    if (a > lspf_pkg::HALF_PI_Q13) begin
      a = a - lspf_pkg::PI_Q13;
      flip = 1'b1;
    end else if (a < -lspf_pkg::HALF_PI_Q13) begin
      a = a + lspf_pkg::PI_Q13;
      flip = 1'b1;
    end

    x = (longint'(rng) * longint'(lspf_pkg::GAIN_Q30) + 32768) >>> 16;
    y = 0;
    z = a * 131072;
    for (int i = 0; i < NUM_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(lspf_pkg::ATAN_Q30[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(lspf_pkg::ATAN_Q30[i]);
      end
    end

    p.px = q14_round(x, flip);
    p.py = q14_round(y, flip);
    p.sidx = idx[10:0];
    return 1'b1;
  endfunction

  // sender: bursts of beats separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : sender
    point_t  pt;
    sample_t smp;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (predict_point(s_tdata, s_tuser, pt))
          expected_points = {expected_points, pt};
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          smp = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= smp.rng;
          s_tuser <= smp.first;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a rotating 8-bit mask that is redrawn now and then
  logic [7:0] stall_mask = 8'hFF;
  logic [2:0] stall_pos = '0;
  int         stall_life = 0;

  always @(posedge clk) begin : receiver
    point_t exp_pt;
    point_t got;
    got = '{px: m_tdata[16:0], py: m_tdata[33:17], sidx: m_tdata[44:34]};
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        err_count++;
        $display("%0t: unexpected point, expected none, got x=%0d y=%0d idx=%0d",
                 $time, $signed(got.px), $signed(got.py), got.sidx);
      end else begin
        exp_pt = expected_points.pop_front();
        if (got.px !== exp_pt.px || got.py !== exp_pt.py || got.sidx !== exp_pt.sidx) begin
          err_count++;
          $display("%0t: point mismatch, expected x=%0d y=%0d idx=%0d, got x=%0d y=%0d idx=%0d",
                   $time, $signed(exp_pt.px), $signed(exp_pt.py), exp_pt.sidx,
                   $signed(got.px), $signed(got.py), got.sidx);
        end
      end
    end
    if (stall_life == 0) begin
      stall_life <= $urandom_range(16, 96);
      stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      stall_life <= stall_life - 1;
    end
    stall_pos <= stall_pos + 3'd1;
    m_tready <= stall_mask[stall_pos];
  end

  task automatic queue_sample(input logic [15:0] rng, input logic first);
    sample_t smp;
    smp.rng = rng;
    smp.first = first;
    pending_samples = {pending_samples, smp};
  endtask

  // all beats sent, all points back, then enough ready cycles to flush dropped samples
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (pending_samples.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(negedge clk);
    while (quiet < QUIET_CYC) begin
      @(negedge clk);
      if (m_tready)
        quiet++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lspf_pkg::REG_ANGLE_START:   cfg_start = data[15:0];
      lspf_pkg::REG_ANGLE_STEP:    cfg_step = data[13:0];
      lspf_pkg::REG_MIN_RANGE:     cfg_minr = data[15:0];
      lspf_pkg::REG_SAMPLE_STRIDE: cfg_stride = data[7:0];
      lspf_pkg::REG_BOUND_COUNT:   cfg_bcount = data[2:0];
      lspf_pkg::REG_IGNORE_BOUNDS: cfg_bounds = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int start, input int step, input int minr,
                              input int stride, input int bcount,
                              input logic [63:0] bounds);
    write_reg(lspf_pkg::REG_ANGLE_START, 64'(start));
    write_reg(lspf_pkg::REG_ANGLE_STEP, 64'(step));
    write_reg(lspf_pkg::REG_MIN_RANGE, 64'(minr));
    write_reg(lspf_pkg::REG_SAMPLE_STRIDE, 64'(stride));
    write_reg(lspf_pkg::REG_BOUND_COUNT, 64'(bcount));
    write_reg(lspf_pkg::REG_IGNORE_BOUNDS, bounds);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int          start, step, minr, stride, bcount, b0, b1, b2, b3;
    logic [63:0] bounds;
    logic [15:0] rng;
    logic        first;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every point sits on the x axis
    queue_sample(16'h0000, 1'b1);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h8000, 1'b1);
    wait_idle();

    // zero stride acts as one; a full turn from -pi, wrapping past +pi
    program_regs(-lspf_pkg::PI_Q13, 4096, 0, 0, 0, 64'd0);
    for (int i = 0; i < 14; i++)
      queue_sample((i % 3 == 0) ? 16'hFFFF : 16'($urandom), i == 0);
    wait_idle();

    // bound count above four saturates; min range edge; stride two
    program_regs(lspf_pkg::PI_Q13, -4096, 100, 2, 7,
                 {16'd20000, 16'd12000, 16'd5000, 16'd1000});
    queue_sample(16'd100, 1'b1);
    queue_sample(16'd7, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'd0, 1'b0);
    queue_sample(16'd99, 1'b0);
    queue_sample(16'd65534, 1'b0);
    queue_sample(16'd500, 1'b0);
    wait_idle();

    // trailing odd bound, angle equal to the bound is kept
    program_regs(0, 4096, 0, 1, 1, 64'd8192);
    for (int i = 0; i < 4; i++)
      queue_sample(16'd30000, i == 0);
    wait_idle();

    // a longer scan at a coarse stride
    program_regs($urandom_range(0, 2 * lspf_pkg::PI_Q13) - lspf_pkg::PI_Q13,
                 $urandom_range(0, 8192) - 4096, 0, 128, 0, 64'd0);
    for (int i = 0; i < 300; i++)
      queue_sample(16'($urandom), i == 0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      start = (ph == 0) ? -lspf_pkg::PI_Q13 : (ph == 1) ? lspf_pkg::PI_Q13
            : $urandom_range(0, 2 * lspf_pkg::PI_Q13) - lspf_pkg::PI_Q13;
      step = (ph == 2) ? -4096 : (ph == 3) ? 4096
           : ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8192) - 4096
           : $urandom_range(0, 400) - 200;
      minr = (ph == 4) ? 65535
           : ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
      stride = (ph == 5) ? 255 : (ph == 6) ? 0 : $urandom_range(1, 4);
      bcount = (ph == 0) ? 0 : (ph == 1) ? 4 : $urandom_range(0, 7);
      b0 = $urandom_range(0, 8000);
      b1 = b0 + $urandom_range(0, 8000);
      b2 = b1 + $urandom_range(0, 6000);
      b3 = b2 + $urandom_range(0, 6000);
      bounds = {16'(b3), 16'(b2), 16'(b1), 16'(b0)};
      if (ph == 7)
        bounds = '1;
      else if (ph % 4 == 3)
        bounds = {$urandom, $urandom};
      if (ph == 8) begin
        // unused register slots
        write_reg(3'd6, {$urandom, $urandom});
        write_reg(3'd7, {$urandom, $urandom});
      end
      program_regs(start, step, minr, stride, bcount, bounds);
      for (int i = 0; i < 22; i++) begin
        case ($urandom_range(0, 7))
          0: rng = 16'hFFFF;
          1: rng = 16'h0000;
          2: rng = 16'(minr);
          3: rng = 16'(minr - 1);
          default: rng = 16'($urandom);
        endcase
        // last phase is noise: scan starts anywhere
        if (ph == 9)
          first = $urandom_range(0, 1);
        else
          first = (i == 0) || ($urandom_range(0, 29) == 0);
        queue_sample(rng, first);
      end
      wait_idle();
    end

    if (err_count == 0)
      $display("tb_lidar_scan_point_filter: done, clean");
    else
      $display("tb_lidar_scan_point_filter: done, errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_lidar_scan_point_filter: done, errors");
    $finish;
  end

endmodule
